[rtl/core/csl_pkg.sv]
// Shared constants for the cache set with LRU/FIFO replacement.
// No dependencies; compiled first.
package csl_pkg;

   // Port widths fixed by the transaction format
   localparam int TAG_PORT_W = 32;
   localparam int MODE_W     = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Access modes
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INVAL = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PROBE = 2'd3;

   // Register index (byte address bit 2)
   localparam logic CSR_IDX_POLICY = 1'b0;
   localparam logic CSR_IDX_ALLOC  = 1'b1;

   // Replacement policy codes
   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

endpackage

[rtl/core/csl_channel_if.sv]
// Valid/ready channel interfaces for request and response transactions.
// Depends on csl_pkg.
interface csl_req_if;
   import csl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [TAG_PORT_W-1:0] tag;

   modport source (output valid, output mode, output tag, input ready);
   modport sink   (input valid, input mode, input tag, output ready);
endinterface

interface csl_rsp_if;
   import csl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic                  evict_dirty;
   logic [TAG_PORT_W-1:0] victim_tag;
   logic                  removed_dirty;

   modport source (output valid, output hit, output evict_dirty,
                   output victim_tag, output removed_dirty, input ready);
   modport sink   (input valid, input hit, input evict_dirty,
                   input victim_tag, input removed_dirty, output ready);
endinterface

[rtl/core/cache_set_lru_fifo_unit.sv]
// One set of a write-back set-associative cache with LRU/FIFO replacement.
// Depends on csl_pkg and the channel interfaces in csl_channel_if.sv.

// One cache set of WAYS ways. Each request transaction (read, write,
// invalidate or probe of a tag) produces exactly one response transaction.
// A request is captured in an input register; once the output register can
// take a response, all ways compare the tag in parallel, the set state
// (valid, dirty, tags and the recency and fill rank orders) is updated, and
// the response is written to the output register. One transaction is taken
// every clock while responses are not stalled: the set state is read and
// written in that compare-and-update cycle, so back-to-back requests to the
// same tag see each other's effect. The output register holds a response
// while rsp_chan.ready is low; the input register keeps accepting as long as
// the response ahead can move. Ranks: 0 is the oldest way, WAYS-1 the newest;
// the victim on a full set is the way of rank 0 in the order selected by the
// policy register. Registers (APB, byte addresses): 0x0 replacement policy
// (0 LRU, 1 FIFO, reset 0), 0x4 write allocate (reset 1). Change them only
// while no transaction is in flight.
module cache_set_lru_fifo_unit #(
   parameter int WAYS     = 8,
   parameter int TAG_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   csl_req_if.sink                        req_chan,
   csl_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [csl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [csl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [csl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import csl_pkg::*;

   // Stored tag width: tags above the port width never reach the set
   localparam int TW     = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W  = RANK_W;
   localparam logic [RANK_W-1:0] NEWEST = RANK_W'(WAYS - 1);

   // ---------------- configuration registers ----------------
   logic policy_ff, policy_in;
   logic alloc_ff, alloc_in;
   logic csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_comb begin
      policy_in = policy_ff;
      alloc_in  = alloc_ff;
      if (csr_wr) begin
         case (paddr[2])
            CSR_IDX_POLICY: policy_in = pwdata[0];
            CSR_IDX_ALLOC:  alloc_in  = pwdata[0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_IDX_POLICY: prdata = CSR_DATA_W'(policy_ff);
         CSR_IDX_ALLOC:  prdata = CSR_DATA_W'(alloc_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic              in_valid_ff, in_valid_in;
   logic [MODE_W-1:0] in_mode_ff, in_mode_in;
   logic [TW-1:0]     in_tag_ff, in_tag_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_hit_ff, out_hit_in;
   logic              out_wb_ff, out_wb_in;
   logic [TAG_PORT_W-1:0] out_vtag_ff, out_vtag_in;
   logic              out_rdirty_ff, out_rdirty_in;

   logic advance;   // input-register transaction executes this cycle
   logic req_take;

   assign advance  = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | advance;
   assign req_take = req_chan.valid & req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_mode_in  = in_mode_ff;
      in_tag_in   = in_tag_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_mode_in  = req_chan.mode;
         in_tag_in   = req_chan.tag[TW-1:0];
      end
   end

   // ---------------- set state ----------------
   logic [TW-1:0]     tags_ff [WAYS];
   logic [TW-1:0]     tags_in [WAYS];
   logic [WAYS-1:0]   valid_ff, valid_in;
   logic [WAYS-1:0]   dirty_ff, dirty_in;
   logic [RANK_W-1:0] rec_rank_ff  [WAYS];
   logic [RANK_W-1:0] rec_rank_in  [WAYS];
   logic [RANK_W-1:0] fill_rank_ff [WAYS];
   logic [RANK_W-1:0] fill_rank_in [WAYS];

   // lookup
   logic [WAYS-1:0]  hit_vec;
   logic             hit_any;
   logic [WAY_W-1:0] hit_way;
   logic             free_any;
   logic [WAY_W-1:0] free_way;
   logic [WAY_W-1:0] old_way;
   logic [WAY_W-1:0] victim_way;
   logic             victim_dirty;
   logic [RANK_W-1:0] sel_rank;

   always_comb begin
      hit_way  = '0;
      old_way  = '0;
      free_way = '0;
      for (int i = 0; i < WAYS; i++) begin
         hit_vec[i] = valid_ff[i] & (tags_ff[i] == in_tag_ff);
         // ways are one-hot on hit and on rank 0, so OR-encode
         if (hit_vec[i]) hit_way = hit_way | WAY_W'(i);
         sel_rank = (policy_ff == POLICY_FIFO) ? fill_rank_ff[i] : rec_rank_ff[i];
         if (sel_rank == '0) old_way = old_way | WAY_W'(i);
      end
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_way = WAY_W'(i);
      end
      hit_any      = |hit_vec;
      free_any     = ~&valid_ff;
      victim_way   = free_any ? free_way : old_way;
      victim_dirty = ~free_any & dirty_ff[victim_way];
   end

   // next state and response
   logic             do_fill;
   logic             rec_touch;
   logic [WAY_W-1:0] touch_way;
   logic [RANK_W-1:0] rec_old, fill_old;

   always_comb begin
      tags_in      = tags_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      rec_rank_in  = rec_rank_ff;
      fill_rank_in = fill_rank_ff;
      do_fill      = 1'b0;
      rec_touch    = 1'b0;
      out_hit_in    = 1'b0;
      out_wb_in     = 1'b0;
      out_vtag_in   = '0;
      out_rdirty_in = 1'b0;

      case (in_mode_ff)
         MODE_PROBE: begin
            out_hit_in = hit_any;
         end
         MODE_INVAL: begin
            out_hit_in = hit_any;
            if (hit_any) begin
               out_rdirty_in     = dirty_ff[hit_way];
               valid_in[hit_way] = 1'b0;
               dirty_in[hit_way] = 1'b0;
            end
         end
         default: begin
            // read or write
            if (hit_any) begin
               out_hit_in = 1'b1;
               if (in_mode_ff == MODE_WRITE) dirty_in[hit_way] = 1'b1;
               rec_touch = (policy_ff == POLICY_LRU);
            end else if (!((in_mode_ff == MODE_WRITE) && !alloc_ff)) begin
               do_fill   = 1'b1;
               rec_touch = 1'b1;
               out_wb_in = victim_dirty;
               if (victim_dirty) out_vtag_in = TAG_PORT_W'(tags_ff[victim_way]);
               tags_in[victim_way]  = in_tag_ff;
               valid_in[victim_way] = 1'b1;
               dirty_in[victim_way] = (in_mode_ff == MODE_WRITE);
            end
         end
      endcase

      // make the touched way newest in the affected rank orders
      touch_way = do_fill ? victim_way : hit_way;
      rec_old   = rec_rank_ff[touch_way];
      fill_old  = fill_rank_ff[touch_way];
      if (rec_touch) begin
         for (int i = 0; i < WAYS; i++) begin
            if (rec_rank_ff[i] > rec_old) rec_rank_in[i] = rec_rank_ff[i] - 1'b1;
         end
         rec_rank_in[touch_way] = NEWEST;
      end
      if (do_fill) begin
         for (int i = 0; i < WAYS; i++) begin
            if (fill_rank_ff[i] > fill_old) fill_rank_in[i] = fill_rank_ff[i] - 1'b1;
         end
         fill_rank_in[touch_way] = NEWEST;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) out_valid_in = 1'b0;
      if (advance) out_valid_in = 1'b1;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_LRU;
         alloc_ff     <= 1'b1;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         for (int i = 0; i < WAYS; i++) begin
            rec_rank_ff[i]  <= RANK_W'(i);
            fill_rank_ff[i] <= RANK_W'(i);
         end
      end else begin
         policy_ff    <= policy_in;
         alloc_ff     <= alloc_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            valid_ff     <= valid_in;
            dirty_ff     <= dirty_in;
            rec_rank_ff  <= rec_rank_in;
            fill_rank_ff <= fill_rank_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_mode_ff <= in_mode_in;
      in_tag_ff  <= in_tag_in;
      if (advance) begin
         tags_ff       <= tags_in;
         out_hit_ff    <= out_hit_in;
         out_wb_ff     <= out_wb_in;
         out_vtag_ff   <= out_vtag_in;
         out_rdirty_ff <= out_rdirty_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.hit           = out_hit_ff;
   assign rsp_chan.evict_dirty   = out_wb_ff;
   assign rsp_chan.victim_tag    = out_vtag_ff;
   assign rsp_chan.removed_dirty = out_rdirty_ff;

endmodule

[rtl/core/csl_checker.sv]
// Port-level assertions for cache_set_lru_fifo_unit, with bind.
// Depends on csl_pkg and cache_set_lru_fifo_unit.
module csl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_hit,
   input logic                           rsp_evict_dirty,
   input logic [csl_pkg::TAG_PORT_W-1:0] rsp_victim_tag,
   input logic                           rsp_removed_dirty
);
   import csl_pkg::*;

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // victim tag only carried with a writeback
   a_vtag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evict_dirty |-> rsp_victim_tag == '0)
      else $error("victim tag without writeback");

   // eviction only happens on a miss
   a_wb_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evict_dirty |-> !rsp_hit && !rsp_removed_dirty)
      else $error("writeback reported on a hit");

   // a dirty removal needs a matching way
   a_rdirty_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed_dirty |-> rsp_hit)
      else $error("removed dirty without hit");

endmodule

bind cache_set_lru_fifo_unit csl_checker u_csl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_hit           (rsp_chan.hit),
   .rsp_evict_dirty   (rsp_chan.evict_dirty),
   .rsp_victim_tag    (rsp_chan.victim_tag),
   .rsp_removed_dirty (rsp_chan.removed_dirty)
);

[verif/tb_top.sv]
// Testbench for cache_set_lru_fifo_unit: directed and random set traffic
// checked against an in-bench model of the set. Depends on csl_pkg and
// the channel interfaces in csl_channel_if.sv.
`timescale 1ns / 100ps

module tb_top;
   import csl_pkg::*;

   localparam int WAYS        = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CSR_ADDR_W-1:0] ADDR_POLICY = {CSR_IDX_POLICY, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_ALLOC  = {CSR_IDX_ALLOC, 2'b00};

   typedef struct packed {
      logic        hit;
      logic        evict_dirty;
      logic [31:0] victim_tag;
      logic        removed_dirty;
   } access_outcome_type;

   logic clock;
   logic reset;

   // config port
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   csl_req_if req_if ();
   csl_rsp_if rsp_if ();

   cache_set_lru_fifo_unit #(
      .WAYS    (WAYS),
      .TAG_BITS(32)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // ---------------------------------------------------------------
   // Set model: tags, valid/dirty, and two rank orders
   // (rank 0 = oldest way, WAYS-1 = newest).
   // ---------------------------------------------------------------
   logic [31:0]              way_tag   [WAYS];
   logic [WAYS-1:0]          way_valid;
   logic [WAYS-1:0]          way_dirty;
   logic [WAYS-1:0][2:0]     recency_rank;
   logic [WAYS-1:0][2:0]     fill_rank;
   logic                     policy_sel;
   logic                     alloc_on_write;

   access_outcome_type access_outcomes[$];   // outcomes still owed by the DUT
   int  mismatch_count;
   int  cycle_count;
   int  req_idle_pct;
   int  rsp_stall_pct;
   logic [31:0] tag_pool[16];

   // Move a way to newest; ranks above its old rank slide down by one.
   function automatic logic [WAYS-1:0][2:0] promote(input logic [WAYS-1:0][2:0] r,
                                                    input int w);
      logic [2:0] old;
      old = r[w];
      for (int i = 0; i < WAYS; i++)
         if (r[i] > old) r[i] = r[i] - 3'd1;
      r[w] = 3'(WAYS - 1);
      return r;
   endfunction

   function automatic int oldest_way(input logic [WAYS-1:0][2:0] r);
      int best;
      best = 0;
      for (int i = 1; i < WAYS; i++)
         if (r[i] < r[best]) best = i;
      return best;
   endfunction

   // Apply one access to the set model and return the response it owes.
   function automatic access_outcome_type cache_set_access(input logic [MODE_W-1:0] mode,
                                                           input logic [31:0] tag);
      access_outcome_type o;
      int hit_way;
      int fill_way;
      o = '0;
      hit_way = -1;
      for (int i = 0; i < WAYS; i++)
         if (hit_way < 0 && way_valid[i] && way_tag[i] == tag) hit_way = i;
      case (mode)
         MODE_PROBE: o.hit = (hit_way >= 0);
         MODE_INVAL: begin
            if (hit_way >= 0) begin
               o.hit = 1'b1;
               o.removed_dirty = way_dirty[hit_way];
               way_valid[hit_way] = 1'b0;
               way_dirty[hit_way] = 1'b0;
            end
         end
         default: begin
            if (hit_way >= 0) begin
               o.hit = 1'b1;
               if (mode == MODE_WRITE) way_dirty[hit_way] = 1'b1;
               // FIFO hit leaves both orders alone
               if (policy_sel == POLICY_LRU) recency_rank = promote(recency_rank, hit_way);
            end else if (!(mode == MODE_WRITE && !alloc_on_write)) begin
               fill_way = -1;
               for (int i = 0; i < WAYS; i++)
                  if (fill_way < 0 && !way_valid[i]) fill_way = i;
               if (fill_way < 0) begin
                  fill_way = oldest_way(policy_sel == POLICY_FIFO ? fill_rank : recency_rank);
                  if (way_dirty[fill_way]) begin
                     o.evict_dirty = 1'b1;
                     o.victim_tag = way_tag[fill_way];
                  end
               end
               way_tag[fill_way]   = tag;
               way_valid[fill_way] = 1'b1;
               way_dirty[fill_way] = (mode == MODE_WRITE);
               recency_rank = promote(recency_rank, fill_way);
               fill_rank    = promote(fill_rank, fill_way);
            end
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------
   // Clock, timeout, response-side backpressure
   // ---------------------------------------------------------------
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d responses owed",
                  cycle_count, access_outcomes.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);

   // ---------------------------------------------------------------
   // Monitor: check the response first, then model the accepted
   // request. A request passes the input and then the output register, so its
   // response never shows at the accepting edge; order here never matters.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      access_outcome_type got;
      access_outcome_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.hit, rsp_if.evict_dirty, rsp_if.victim_tag,
                    rsp_if.removed_dirty};
            if (access_outcomes.size() == 0) begin
               report_mismatch("response with none owed", got.victim_tag, 32'h0);
            end else begin
               want = access_outcomes.pop_front();
               if (got.hit !== want.hit)
                  report_mismatch("hit", 32'(got.hit), 32'(want.hit));
               if (got.evict_dirty !== want.evict_dirty)
                  report_mismatch("evict_dirty", 32'(got.evict_dirty),
                                  32'(want.evict_dirty));
               if (got.victim_tag !== want.victim_tag)
                  report_mismatch("victim_tag", got.victim_tag, want.victim_tag);
               if (got.removed_dirty !== want.removed_dirty)
                  report_mismatch("removed_dirty", 32'(got.removed_dirty),
                                  32'(want.removed_dirty));
            end
         end
         if (req_if.valid && req_if.ready)
            access_outcomes.push_back(cache_set_access(req_if.mode, req_if.tag));
      end
   end

   // ---------------------------------------------------------------
   // Drivers: all called at a falling edge, return at a falling edge.
   // ---------------------------------------------------------------

   // One request transaction; valid stays up after acceptance so the
   // next call can stream back to back.
   task automatic issue_access(input logic [MODE_W-1:0] mode, input logic [31:0] tag);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode  <= mode;
      req_if.tag   <= tag;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and wait for every owed response, plus pipeline slack.
   task automatic drain_set;
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (access_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write then read-back; only called with the set drained.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {31'b0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_POLICY) policy_sel = value;
      else alloc_on_write = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[0] !== value)
         report_mismatch("register read-back", prdata, 32'(value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      // one idle cycle so back-to-back writes never collide on psel
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Fill all ways with extreme tags, then hits, probes and refreshes.
   task automatic test_fill_and_hit;
      csr_write(ADDR_POLICY, POLICY_LRU);
      csr_write(ADDR_ALLOC, 1'b1);
      issue_access(MODE_WRITE, 32'h0000_0000);
      issue_access(MODE_READ,  32'hFFFF_FFFF);
      issue_access(MODE_WRITE, 32'hAAAA_AAAA);
      issue_access(MODE_READ,  32'h5555_5555);
      issue_access(MODE_WRITE, 32'h8000_0000);
      issue_access(MODE_READ,  32'h0000_0001);
      issue_access(MODE_WRITE, 32'h7FFF_FFFF);
      issue_access(MODE_READ,  32'h1234_5678);   // set now full
      issue_access(MODE_PROBE, 32'h0000_0000);   // probe hit
      issue_access(MODE_PROBE, 32'hDEAD_BEEF);   // probe miss
      issue_access(MODE_READ,  32'h0000_0000);   // LRU refresh
      issue_access(MODE_WRITE, 32'hFFFF_FFFF);   // write hit marks dirty
   endtask

   // Evictions of dirty and clean victims, invalidates, refill of a hole.
   task automatic test_evict_and_invalidate;
      issue_access(MODE_READ,  32'h0BAD_F00D);   // evicts dirty LRU way
      issue_access(MODE_READ,  32'h0BAD_F00E);   // evicts clean way
      issue_access(MODE_INVAL, 32'h8000_0000);   // dirty removal
      issue_access(MODE_INVAL, 32'h0000_0001);   // clean removal
      issue_access(MODE_INVAL, 32'hDEAD_BEEF);   // invalidate miss
      issue_access(MODE_READ,  32'h1357_9BDF);   // lowest invalid way
      drain_set;
   endtask

   // FIFO victims and write misses that must not allocate.
   task automatic test_fifo_no_alloc;
      csr_write(ADDR_POLICY, POLICY_FIFO);
      csr_write(ADDR_ALLOC, 1'b0);
      issue_access(MODE_WRITE, 32'hCAFE_F00D);   // dropped write miss
      issue_access(MODE_READ,  32'h0000_0000);   // hit, no FIFO refresh
      issue_access(MODE_READ,  32'h2468_ACE0);   // fills the last hole
      issue_access(MODE_READ,  32'h1111_1111);   // oldest fill goes
      issue_access(MODE_WRITE, 32'h0000_0000);   // now a dropped miss
      drain_set;
   endtask

   // Mostly a small tag pool so ways hit, fill and evict; some noise tags.
   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct, input logic policy,
                                      input logic alloc);
      int pool_n;
      int pick;
      logic [MODE_W-1:0] mode;
      logic [31:0] tag;
      csr_write(ADDR_POLICY, policy);
      csr_write(ADDR_ALLOC, alloc);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      pool_n = $urandom_range(16, 6);
      for (int i = 0; i < 16; i++) tag_pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 35)      mode = MODE_READ;
         else if (pick < 70) mode = MODE_WRITE;
         else if (pick < 85) mode = MODE_INVAL;
         else                mode = MODE_PROBE;
         if ($urandom_range(9) == 0) tag = $urandom;
         else tag = tag_pool[$urandom_range(pool_n - 1)];
         issue_access(mode, tag);
      end
      // sender holds off until the set has answered everything
      drain_set;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_if.valid   = 1'b0;
      req_if.mode    = MODE_READ;
      req_if.tag     = '0;
      rsp_if.ready   = 1'b1;
      mismatch_count = 0;
      cycle_count    = 0;
      req_idle_pct   = 0;
      rsp_stall_pct  = 0;
      // model reset state
      way_valid      = '0;
      way_dirty      = '0;
      policy_sel     = POLICY_LRU;
      alloc_on_write = 1'b1;
      for (int i = 0; i < WAYS; i++) begin
         way_tag[i]      = '0;
         recency_rank[i] = 3'(i);
         fill_rank[i]    = 3'(i);
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_fill_and_hit;
      test_evict_and_invalidate;
      test_fifo_no_alloc;
      test_random_traffic(170, 0,  0,  POLICY_LRU,  1'b1);
      test_random_traffic(170, 75, 0,  POLICY_FIFO, 1'b0);
      test_random_traffic(170, 0,  75, POLICY_LRU,  1'b0);
      test_random_traffic(170, 30, 30, POLICY_FIFO, 1'b1);

      // extra quiet cycles for anything the DUT might still emit
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && access_outcomes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/csl_pkg.sv
rtl/core/csl_channel_if.sv
rtl/core/cache_set_lru_fifo_unit.sv
rtl/core/csl_checker.sv
verif/tb_top.sv
